// ===== rtl/core/bpta_pkg.sv =====
// shared types and constants of the block peak threshold alarm
// used by every module in rtl/core; depends on nothing else

package bpta_pkg;

  // field widths
  localparam int CH_W      = 3;
  localparam int SAMPLE_W  = 12;
  localparam int CAL_W     = 16;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 33;
  localparam int PEAK_W    = 26;
  localparam int OUT_W     = 13;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 12;
  localparam int CFG_IDX_W = 2;

  // full scale of the clamped result
  localparam int FULL_SCALE = 2048;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTRAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT     = 2'd2;

  // item actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CAL    = 1'b1;

  localparam logic [PCT_W-1:0] ALERT_RST_PCT = 7'd50;

  // divide by 100: |p|/100 = (|p| >> 2) / 25, reciprocal exact for 29-bit inputs
  localparam int REC_IN_W = 29;
  localparam int REC_M_W  = 30;
  localparam int REC_SH   = 34;
  localparam logic [REC_M_W-1:0] REC_M = 30'd687194768;

  // percent to level: pct * 2048 / 100 = (pct * 83887) >> 12 for pct below 128
  localparam int LVL_M_W = 17;
  localparam int LVL_SH  = 12;
  localparam logic [LVL_M_W-1:0] LVL_M = 17'd83887;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic                    action;
    logic [CH_W-1:0]         channel;
    logic [SAMPLE_W-1:0]     sample;
    logic signed [CAL_W-1:0] gain_value;
    logic signed [CAL_W-1:0] offset_value;
    logic                    last_in_block;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] peak;
    logic                    alarm;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            hit;
    logic            last;
  } meta_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [CAL_W-1:0]  gain;
    meta_t                    meta;
  } smp_t;

  typedef struct packed {
    logic             peak_mode;
    logic [LVL_W-1:0] restrain_lvl;
    logic [LVL_W-1:0] alert_lvl;
  } cfg_t;

  function automatic logic [LVL_W-1:0] pct_to_lvl(input logic [PCT_W-1:0] pct);
    logic [PCT_W+LVL_M_W-1:0] p;
    p = (PCT_W + LVL_M_W)'(pct) * (PCT_W + LVL_M_W)'(LVL_M);
    return p[LVL_SH +: LVL_W];
  endfunction

endpackage

// ===== rtl/core/bpta_front.sv =====
// front part: accepts items, keeps the calibration stores, classifies samples
// depends on bpta_pkg

module bpta_front import bpta_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     full_i,
  output logic     push_o,
  output smp_t     push_data_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = CH_W + 6;

  logic signed [CAL_W-1:0] gain_q [CHANNELS];
  logic signed [CAL_W-1:0] offset_q [CHANNELS];

  logic       f_valid_q, f_valid_d;
  smp_t       f_data_q, f_data_d;
  logic       accept;
  logic       hit;
  logic [IDX_W-1:0] idx;

  // stall while the staged sample cannot enter the queue
  assign in_stall_o = f_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !full_i;
  assign push_data_o = f_data_q;

  // channel lookup
  assign hit = CMP_W'(in_item_i.channel) < CMP_W'(CHANNELS);
  assign idx = IDX_W'(in_item_i.channel);

  // stage a sample with its baseline removed
  always_comb begin
    f_valid_d = f_valid_q;
    f_data_d  = f_data_q;
    if (!in_stall_o) begin
      f_valid_d           = accept && (in_item_i.action == ACT_SAMPLE);
      f_data_d.diff       = DIFF_W'($signed({1'b0, in_item_i.sample}))
                            - DIFF_W'(offset_q[idx]);
      f_data_d.gain       = gain_q[idx];
      f_data_d.meta.channel = in_item_i.channel;
      f_data_d.meta.hit   = hit;
      f_data_d.meta.last  = in_item_i.last_in_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_data_q <= f_data_d;
  end

  // calibration stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        gain_q[i]   <= '0;
        offset_q[i] <= '0;
      end
    end else if (accept && (in_item_i.action == ACT_CAL) && hit) begin
      gain_q[idx]   <= in_item_i.gain_value;
      offset_q[idx] <= in_item_i.offset_value;
    end
  end

endmodule

// ===== rtl/core/bpta_fifo.sv =====
// short queue of staged samples between front and back
// depends on bpta_pkg

module bpta_fifo import bpta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  smp_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output smp_t data_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  smp_t mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/bpta_back.sv =====
// back part: scaling pipeline, running peaks, result and alarm output
// depends on bpta_pkg

module bpta_back import bpta_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      fifo_valid_i,
  input  smp_t      fifo_data_i,
  output logic      fifo_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W = PEAK_W + IDX_W;
  localparam int REC_W = REC_IN_W + REC_M_W;
  localparam int QUO_W = REC_W - REC_SH;
  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(FULL_SCALE);
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

  // pipeline stages
  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  meta_t                    s1_meta_q, s2_meta_q, s3_meta_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic                     s2_neg_q;
  logic [REC_W-1:0]         s2_rec_q;
  logic signed [PEAK_W-1:0] s3_y_q;

  // running state
  logic signed [PEAK_W-1:0] chan_peak_q [CHANNELS];
  logic [CHANNELS-1:0]      chan_seen_q;
  logic signed [PEAK_W-1:0] group_peak_q;
  logic                     group_seen_q;
  logic signed [SUM_W-1:0]  sum_q;

  // result and output registers
  logic                    res_valid_q;
  logic signed [SUM_W-1:0] res_val_q;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  logic en, res_move, out_load;
  logic signed [PROD_W-1:0] p_abs;
  logic [REC_IN_W-1:0]      rec_in;
  logic [QUO_W-1:0]         quo;
  logic signed [PEAK_W-1:0] quo_s, y_d;
  logic [IDX_W-1:0]         idx;
  logic signed [PEAK_W-1:0] cur_peak, grp_new;
  logic                     cur_seen, upd, blk_end;
  logic signed [SUM_W-1:0]  delta, sum_new, raw;
  logic signed [OUT_W-1:0]  peak_c;
  logic signed [OUT_W:0]    margin;

  // flow control: the pipeline halts only when a block result cannot leave
  assign res_move   = !out_valid_q || !out_stall_i;
  assign out_load   = res_valid_q && res_move;
  assign en         = !(s3_valid_q && s3_meta_q.last && res_valid_q && !res_move);
  assign fifo_pop_o = en && fifo_valid_i;

  // scaling: magnitude, reciprocal multiply, sign restore
  assign p_abs  = s1_prod_q[PROD_W-1] ? -s1_prod_q : s1_prod_q;
  assign rec_in = p_abs[REC_IN_W+1:2];
  assign quo    = s2_rec_q[REC_SH +: QUO_W];
  assign quo_s  = $signed(PEAK_W'(quo));
  assign y_d    = s2_neg_q ? -quo_s : quo_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= fifo_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q <= fifo_data_i.meta;
      s1_prod_q <= PROD_W'(fifo_data_i.diff) * PROD_W'(fifo_data_i.gain);
      s2_meta_q <= s1_meta_q;
      s2_neg_q  <= s1_prod_q[PROD_W-1];
      s2_rec_q  <= REC_W'(rec_in) * REC_W'(REC_M);
      s3_meta_q <= s2_meta_q;
      s3_y_q    <= y_d;
    end
  end

  // peak tracking of the item in the last stage
  assign idx      = IDX_W'(s3_meta_q.channel);
  assign cur_peak = chan_peak_q[idx];
  assign cur_seen = chan_seen_q[idx];
  assign upd      = en && s3_valid_q && s3_meta_q.hit;
  assign blk_end  = en && s3_valid_q && s3_meta_q.last;

  always_comb begin
    grp_new = group_peak_q;
    delta   = '0;
    if (s3_meta_q.hit) begin
      if (!group_seen_q || (s3_y_q > group_peak_q)) begin
        grp_new = s3_y_q;
      end
      if (!cur_seen) begin
        delta = SUM_W'(s3_y_q);
      end else if (s3_y_q > cur_peak) begin
        delta = SUM_W'(s3_y_q) - SUM_W'(cur_peak);
      end
    end
    sum_new = sum_q + delta;
    raw     = cfg_i.peak_mode ? sum_new : SUM_W'(grp_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_peak_q[i] <= '0;
      end
      chan_seen_q  <= '0;
      group_peak_q <= '0;
      group_seen_q <= 1'b0;
      sum_q        <= '0;
    end else if (blk_end) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_peak_q[i] <= '0;
      end
      chan_seen_q  <= '0;
      group_peak_q <= '0;
      group_seen_q <= 1'b0;
      sum_q        <= '0;
    end else if (upd) begin
      group_peak_q     <= grp_new;
      group_seen_q     <= 1'b1;
      sum_q            <= sum_new;
      chan_seen_q[idx] <= 1'b1;
      if (!cur_seen || (s3_y_q > cur_peak)) begin
        chan_peak_q[idx] <= s3_y_q;
      end
    end
  end

  // block result staging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (blk_end) begin
      res_valid_q <= 1'b1;
    end else if (res_move) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_end) begin
      res_val_q <= raw;
    end
  end

  // clamp to full scale, subtract the restrain level and compare against the alert level
  always_comb begin
    priority if (res_val_q > POS_LIM) begin
      peak_c = OUT_W'(POS_LIM);
    end else if (res_val_q < NEG_LIM) begin
      peak_c = OUT_W'(NEG_LIM);
    end else begin
      peak_c = OUT_W'(res_val_q);
    end
    margin = $signed({peak_c[OUT_W-1], peak_c}) - $signed({2'b00, cfg_i.restrain_lvl});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.peak  <= peak_c;
      out_item_q.alarm <= margin > $signed({2'b00, cfg_i.alert_lvl});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/block_peak_threshold_alarm_top.sv =====
// Block peak detector with threshold alarm.
// Input channel (in_valid_i / in_stall_o / in_item_i): calibration items load a
// channel's gain and offset; sample items are scaled as (sample - offset) * gain / 100
// and tracked as a group maximum and as per-channel maxima. The sample flagged
// last_in_block closes the block and yields one item on the output channel
// (out_valid_o / out_stall_i / out_item_o): clamped peak or peak sum with alarm flag.
// Configuration (cfg_valid_i / cfg_ready_o, index and data) is always ready; the user
// must write it only while the block is idle, the block itself does not enforce this.
// Throughput: one item per clock while in_stall_o is low, set by the registered input
// stage and the one-per-cycle scaling pipeline. After the edge that accepts the closing
// sample, the result passes through the input stage, queue, multiply, reciprocal, sign
// restore, tracking and output registers before out_valid_o rises.
// Reset clears calibration, running peaks and configuration (alert level 50%).
// A stalled output holds its item and one more result waits behind it; the back
// part keeps running until a third result would be needed, the queue then fills
// and in_stall_o rises.
// depends on bpta_pkg, bpta_front, bpta_fifo, bpta_back

module block_peak_threshold_alarm_top import bpta_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PCT_W-1:0]     cfg_wdata_i
);

  cfg_t cfg_q;
  logic push, full, fifo_valid, pop;
  smp_t push_data, fifo_data;

  // configuration registers, percent stored as a level
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_mode    <= 1'b0;
      cfg_q.restrain_lvl <= '0;
      cfg_q.alert_lvl    <= pct_to_lvl(ALERT_RST_PCT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        REG_PEAK_MODE: cfg_q.peak_mode    <= cfg_wdata_i[0];
        REG_RESTRAIN:  cfg_q.restrain_lvl <= pct_to_lvl(cfg_wdata_i);
        REG_ALERT:     cfg_q.alert_lvl    <= pct_to_lvl(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  bpta_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  bpta_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(fifo_valid),
    .data_o (fifo_data)
  );

  bpta_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_valid_i(fifo_valid),
    .fifo_data_i (fifo_data),
    .fifo_pop_o  (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
